FILE: rtl/iie_pkg.sv
// Shared types, constants and opcodes of the integer instruction execute core.
package iie_pkg;

  localparam int MemWords  = 65536;
  localparam int MemAw     = $clog2(MemWords);
  localparam int StackDep  = 1024;
  localparam int StackAw   = $clog2(StackDep);
  localparam int PcW       = 15;
  localparam int RegCount  = 32;
  localparam int RegAw     = $clog2(RegCount);
  localparam int QueueDep  = 2;

  typedef enum logic [4:0] {
    K_NOP = 5'd0, K_ADD = 5'd1, K_SUB = 5'd2, K_MUL = 5'd3, K_AND = 5'd4,
    K_OR = 5'd5, K_NOR = 5'd6, K_XOR = 5'd7,
    K_ADDI = 5'd8, K_SUBI = 5'd9, K_MULI = 5'd10, K_ANDI = 5'd11,
    K_ORI = 5'd12, K_NORI = 5'd13, K_XORI = 5'd14,
    K_LOAD = 5'd15, K_STORE = 5'd16,
    K_BEQ = 5'd17, K_BNE = 5'd18, K_BGT = 5'd19, K_BLT = 5'd20,
    K_BGE = 5'd21, K_BLE = 5'd22,
    K_JUMP = 5'd23, K_CALL = 5'd24, K_RET = 5'd25
  } kind_t;

  localparam logic [2:0] FaultNone  = 3'd0;
  localparam logic [2:0] FaultOver  = 3'd1;
  localparam logic [2:0] FaultUnder = 3'd2;
  localparam logic [2:0] FaultIll   = 3'd3;
  localparam logic [2:0] FaultMem   = 3'd4;

  // Operation class decided by the front part.
  typedef enum logic [2:0] {
    C_NOP, C_ALU, C_MEM, C_BR, C_JUMP, C_CALL, C_RET, C_ILL
  } op_class_t;

  // States of the back part.
  typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_EXEC} back_state_t;

  typedef struct packed {
    op_class_t   cls;
    logic [4:0]  kind;
    logic        use_imm;
    logic [RegAw-1:0] r1;
    logic [RegAw-1:0] r2;
    logic [RegAw-1:0] r3;
    logic [31:0] imm;
    logic [15:0] target;
  } uop_t;

endpackage

FILE: rtl/iie_ram.sv
// Generic single-port RAM with registered read.
module iie_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/iie_front.sv
// Front part: accepts requests, classifies them and queues them for execution.
module iie_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4:0]          kind,
  input  logic [4:0]          first_reg,
  input  logic [4:0]          second_reg,
  input  logic [4:0]          third_reg,
  input  logic [31:0]         immediate,
  input  logic [15:0]         target,
  output logic                uop_valid,
  input  logic                uop_ready,
  output iie_pkg::uop_t       uop
);
  localparam int QW = $clog2(iie_pkg::QueueDep);

  iie_pkg::uop_t    q [iie_pkg::QueueDep];
  logic [QW-1:0]    wr_ptr, rd_ptr;
  logic [QW:0]      count;
  iie_pkg::uop_t    dec;
  logic             push, pop;

  always_comb begin
    dec        = '0;
    dec.kind   = kind;
    dec.r1     = first_reg[iie_pkg::RegAw-1:0];
    dec.r2     = second_reg[iie_pkg::RegAw-1:0];
    dec.r3     = third_reg[iie_pkg::RegAw-1:0];
    dec.imm    = immediate;
    dec.target = target;
    dec.use_imm = 1'b0;
    unique case (kind)
      iie_pkg::K_NOP: dec.cls = iie_pkg::C_NOP;
      iie_pkg::K_ADD, iie_pkg::K_SUB, iie_pkg::K_MUL, iie_pkg::K_AND,
      iie_pkg::K_OR, iie_pkg::K_NOR, iie_pkg::K_XOR: dec.cls = iie_pkg::C_ALU;
      iie_pkg::K_ADDI, iie_pkg::K_SUBI, iie_pkg::K_MULI, iie_pkg::K_ANDI,
      iie_pkg::K_ORI, iie_pkg::K_NORI, iie_pkg::K_XORI: begin
        dec.cls = iie_pkg::C_ALU;
        dec.use_imm = 1'b1;
      end
      iie_pkg::K_LOAD, iie_pkg::K_STORE: dec.cls = iie_pkg::C_MEM;
      iie_pkg::K_BEQ, iie_pkg::K_BNE, iie_pkg::K_BGT, iie_pkg::K_BLT,
      iie_pkg::K_BGE, iie_pkg::K_BLE: dec.cls = iie_pkg::C_BR;
      iie_pkg::K_JUMP: dec.cls = iie_pkg::C_JUMP;
      iie_pkg::K_CALL: dec.cls = iie_pkg::C_CALL;
      iie_pkg::K_RET:  dec.cls = iie_pkg::C_RET;
      default:         dec.cls = iie_pkg::C_ILL;
    endcase
  end

  assign in_ready  = (count != (QW+1)'(iie_pkg::QueueDep));
  assign uop_valid = (count != '0);
  assign uop       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = uop_valid && uop_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QW+1)'(iie_pkg::QueueDep)) else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !pop) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    count == (QW+1)'(iie_pkg::QueueDep) |-> !push) else $error("push into full queue");
endmodule

FILE: rtl/iie_back.sv
// Back part: register file, data memory, return stack and program counter.
module iie_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         program_length,
  input  logic                uop_valid,
  output logic                uop_ready,
  input  iie_pkg::uop_t       uop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [56:0]         res_data
);
  localparam int MW = iie_pkg::MemAw;
  localparam int SW = iie_pkg::StackAw;
  localparam int PW = iie_pkg::PcW;

  iie_pkg::back_state_t state, state_next;

  logic [31:0] regs [iie_pkg::RegCount];
  logic [iie_pkg::RegCount-1:0] written;

  // Data memory is cleared after reset by a sweep.
  logic [MW:0]    clr_addr;
  logic           clearing;
  logic [PW-1:0]  pc;
  logic [SW:0]    depth;
  iie_pkg::uop_t  cur;

  logic [31:0] a, b, c, opb, alu_out, addr_sum, mem_rdata;
  logic [14:0] stk_rdata;
  logic        take, mem_oob;
  logic [2:0]  fault;
  logic [PW-1:0] next_pc, seq_pc;
  logic        wv;
  logic [31:0] wval;
  logic        mem_we, stk_we;
  logic [MW-1:0] mem_addr;
  logic [SW-1:0] stk_addr;
  logic        out_full;
  logic        fire;

  function automatic logic [31:0] rf_rd(input logic [31:0] v, input logic w);
    rf_rd = w ? v : 32'd0;
  endfunction

  assign a = rf_rd(regs[cur.r1], written[cur.r1]);
  assign b = rf_rd(regs[cur.r2], written[cur.r2]);
  assign c = rf_rd(regs[cur.r3], written[cur.r3]);
  assign clearing = (state == iie_pkg::S_CLEAR);

  // Address of the queued request is computed from the head before capture,
  // so that the memory read lands in the execute cycle.
  logic [31:0] hb, haddr;
  assign hb    = rf_rd(regs[uop.r2], written[uop.r2]);
  assign haddr = hb + uop.imm;

  always_comb begin
    opb = cur.use_imm ? cur.imm : c;
    case (cur.kind[2:0] + (cur.use_imm ? 3'd1 : 3'd0))
      3'd1:    alu_out = b + opb;
      3'd2:    alu_out = b - opb;
      3'd3:    alu_out = b * opb;
      3'd4:    alu_out = b & opb;
      3'd5:    alu_out = b | opb;
      3'd6:    alu_out = ~(b | opb);
      default: alu_out = b ^ opb;
    endcase
  end

  assign addr_sum = b + cur.imm;
  assign mem_oob  = (addr_sum >= 32'(iie_pkg::MemWords));

  always_comb begin
    unique case (cur.kind)
      iie_pkg::K_BEQ: take = $signed(a) == $signed(b);
      iie_pkg::K_BNE: take = $signed(a) != $signed(b);
      iie_pkg::K_BGT: take = $signed(a) >  $signed(b);
      iie_pkg::K_BLT: take = $signed(a) <  $signed(b);
      iie_pkg::K_BGE: take = $signed(a) >= $signed(b);
      default:        take = $signed(a) <= $signed(b);
    endcase
  end

  assign seq_pc = pc + 1'b1;

  always_comb begin
    fault   = iie_pkg::FaultNone;
    next_pc = seq_pc;
    wv      = 1'b0;
    wval    = 32'd0;
    unique case (cur.cls)
      iie_pkg::C_ALU: begin
        wv = 1'b1;
        wval = alu_out;
      end
      iie_pkg::C_MEM: begin
        if (mem_oob) fault = iie_pkg::FaultMem;
        else if (cur.kind == iie_pkg::K_LOAD) begin
          wv = 1'b1;
          wval = mem_rdata;
        end
      end
      iie_pkg::C_BR: if (take) next_pc = pc + cur.target[PW-1:0];
      iie_pkg::C_JUMP: next_pc = cur.target[PW-1:0];
      iie_pkg::C_CALL: begin
        if (depth == (SW+1)'(iie_pkg::StackDep)) fault = iie_pkg::FaultOver;
        else next_pc = cur.target[PW-1:0];
      end
      iie_pkg::C_RET: begin
        if (depth == '0) fault = iie_pkg::FaultUnder;
        else next_pc = stk_rdata[PW-1:0];
      end
      iie_pkg::C_ILL: fault = iie_pkg::FaultIll;
      default: ;
    endcase
    if (fault != iie_pkg::FaultNone) begin
      next_pc = pc;
      wv = 1'b0;
      wval = 32'd0;
    end
  end

  assign fire = (state == iie_pkg::S_EXEC) && !out_full;

  // Memory port: head address in idle, the current request's address in
  // execute (kept while the result is stalled), sweep while clearing.
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = haddr[MW-1:0];
    if (clearing) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr[MW-1:0];
    end else if (state == iie_pkg::S_EXEC) begin
      mem_addr = addr_sum[MW-1:0];
      mem_we   = fire && cur.kind == iie_pkg::K_STORE && !mem_oob;
    end
  end

  always_comb begin
    stk_we = fire && cur.cls == iie_pkg::C_CALL && fault == iie_pkg::FaultNone;
    if (state == iie_pkg::S_EXEC)
      stk_addr = (cur.cls == iie_pkg::C_RET) ? depth[SW-1:0] - 1'b1 : depth[SW-1:0];
    else
      stk_addr = (uop.kind == iie_pkg::K_RET) ? depth[SW-1:0] - 1'b1 : depth[SW-1:0];
  end

  iie_ram #(.Width(32), .Depth(iie_pkg::MemWords)) u_dmem (
    .clk(clk), .we(mem_we), .addr(mem_addr),
    .wdata(clearing ? 32'd0 : a), .rdata(mem_rdata));

  iie_ram #(.Width(15), .Depth(iie_pkg::StackDep)) u_stack (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(seq_pc), .rdata(stk_rdata));

  always_comb begin
    state_next = state;
    unique case (state)
      iie_pkg::S_CLEAR:
        if (clr_addr == (MW+1)'(iie_pkg::MemWords - 1)) state_next = iie_pkg::S_IDLE;
      iie_pkg::S_IDLE:  if (uop_valid) state_next = iie_pkg::S_EXEC;
      iie_pkg::S_EXEC:  if (fire) state_next = iie_pkg::S_IDLE;
      default: state_next = iie_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    uop_ready = (state == iie_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= iie_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (uop_valid && uop_ready) cur <= uop;
    if (fire && wv) regs[cur.r1] <= wval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      pc        <= '0;
      depth     <= '0;
      written   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (clearing) clr_addr <= clr_addr + 1'b1;
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (fire) begin
        pc        <= next_pc;
        res_valid <= 1'b1;
        if (wv) written[cur.r1] <= 1'b1;
        if (fault == iie_pkg::FaultNone && cur.cls == iie_pkg::C_CALL) depth <= depth + 1'b1;
        if (fault == iie_pkg::FaultNone && cur.cls == iie_pkg::C_RET)  depth <= depth - 1'b1;
      end
    end
  end

  assign out_full = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= {fault,
                   ({1'b0, next_pc} >= program_length),
                   wval,
                   wv ? cur.r1 : 5'd0,
                   wv,
                   next_pc};
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= (SW+1)'(iie_pkg::StackDep)) else $error("stack depth beyond capacity");
  a_fault_holds_pc: assert property (@(posedge clk) disable iff (rst)
    fire && fault != iie_pkg::FaultNone |=> pc == $past(pc)) else $error("fault moved pc");
  a_no_exec_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !fire && !uop_ready) else $error("request taken during clear");
endmodule

FILE: rtl/integer_instruction_execute_core.sv
// Top level of the integer instruction execute core.
//
// Requests arrive on the s_axis channel, one decoded instruction each, and
// each request gives exactly one result on the m_axis channel. The front part
// classifies a request and places it in a two-entry queue; the back part
// reads it, executes it against the register file, the 64K-word data memory
// and the return-address stack, and places the result in an output register.
// In the back part an instruction passes the idle state, which presents the
// memory and stack read addresses and captures the request, and then the
// execute state, which executes with the registered read data. The back part
// takes a new request only after the last one has executed. The program
// length is written on cfg_we/cfg_data; the user must write it only while the
// core is idle, which the core itself does not enforce. After reset the data
// memory is cleared by a sweep, one word a cycle, during which requests queue
// but do not execute. When the receiver holds m_axis_tready low the result is
// held, the back part stops and the queue fills, after which s_axis_tready
// falls.
module integer_instruction_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[4:0], first_reg[9:5], second_reg[14:10], third_reg[19:15],
  // immediate[51:20], target[67:52], zero fill to 72 bits
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[14:0], write_valid[15], write_index[20:16], write_value[52:21],
  // halted[53], fault[56:54], zero fill to 64 bits
  output logic [63:0] m_axis_tdata
);
  logic [15:0]   program_length;
  logic          uop_valid, uop_ready;
  iie_pkg::uop_t uop;
  logic [56:0]   res_data;

  // The configuration register.
  always_ff @(posedge clk) begin
    if (rst)         program_length <= 16'd0;
    else if (cfg_we) program_length <= cfg_data;
  end

  iie_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .kind(s_axis_tdata[4:0]), .first_reg(s_axis_tdata[9:5]),
    .second_reg(s_axis_tdata[14:10]), .third_reg(s_axis_tdata[19:15]),
    .immediate(s_axis_tdata[51:20]), .target(s_axis_tdata[67:52]),
    .uop_valid(uop_valid), .uop_ready(uop_ready), .uop(uop));

  iie_back u_back (
    .clk(clk), .rst(rst), .program_length(program_length),
    .uop_valid(uop_valid), .uop_ready(uop_ready), .uop(uop),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res_data));

  assign m_axis_tdata = {7'd0, res_data};
endmodule
